### rtl/toroidal_life_automaton_defines.svh
// Assertion helpers used by the checker.
`ifndef TOROIDAL_LIFE_AUTOMATON_DEFINES_SVH
`define TOROIDAL_LIFE_AUTOMATON_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLA_ASSERT_HOLD(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tla_pkg.sv
`timescale 1ns / 1ps

package tla_pkg;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int COORD_W   = 6;
	localparam int POS_W     = COORD_W + 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_HEIGHT = 1'd1;
	localparam logic [CFG_W-1:0]     BOARD_SIZE_RESET = 7'd64;

	localparam logic [1:0] OP_ADVANCE = 2'd0;
	localparam logic [1:0] OP_STAMP   = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// remainder unit: one bit per step over a 7-bit magnitude, then a fixup step
	localparam logic [2:0] MOD_LAST = 3'd7;

endpackage

### rtl/toroidal_life_automaton.sv
`timescale 1ns / 1ps

// Wrap-around life board (B3/S23) held in a row memory, one row word per line.
// Command channel: an item is taken when start is high and busy is low.
// Each item gives exactly one result: done pulses for one cycle with
// cell_alive and ignored; the receiver cannot stall and needs no handshake.
// Work per item, from the accept edge to the cycle where done is high:
//   clear, dead stamp cell, anchor off the board: done follows in the next cycle, busy stays low
//   read:    row fetch, then bit select
//   stamp:   two 8-step remainder passes on the shared
//            compare/subtract unit, then a read-modify-write of one row
//   advance: the row unit computes one row per cycle
//            from a three-row window that streams through the single read port
// A new item can be taken in the cycle where done is high.
// Board size registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, which the block does not enforce. An index beyond
// the register list is dropped. Reset sets both sizes to 64 and kills every cell
// at once via per-row valid flags (no clearing pass); clear works the same way.
module toroidal_life_automaton #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tla_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [tla_pkg::COORD_W-1:0]   anchor_x,
	input  logic [tla_pkg::COORD_W-1:0]   anchor_y,
	input  logic [tla_pkg::COORD_W-1:0]   pattern_x,
	input  logic [tla_pkg::COORD_W-1:0]   pattern_y,
	input  logic [tla_pkg::CFG_W-1:0]     pattern_width,
	input  logic [tla_pkg::CFG_W-1:0]     pattern_height,
	input  logic                          pattern_bit,
	output logic                          done,
	output logic                          cell_alive,
	output logic                          ignored
);
	import tla_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RA = $clog2(MAX_HEIGHT);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_ADV_A   = 8'b0000_0010,
		S_ADV_B   = 8'b0000_0100,
		S_ADV_C   = 8'b0000_1000,
		S_ADV_ROW = 8'b0001_0000,
		S_MOD     = 8'b0010_0000,
		S_FETCH   = 8'b0100_0000,
		S_UPDATE  = 8'b1000_0000
	} state_t;

	typedef logic [MAX_WIDTH-1:0] row_t;

	function automatic logic signed [POS_W-1:0] stamp_pos(
		input logic [COORD_W-1:0] p,
		input logic [COORD_W-1:0] a,
		input logic [CFG_W-1:0]   s
	);
		stamp_pos = $signed({2'b00, p}) + $signed({2'b00, a}) - $signed({2'b00, s[CFG_W-1:1]});
	endfunction

	function automatic logic [CFG_W-1:0] pos_mag(input logic signed [POS_W-1:0] v);
		logic [POS_W-1:0] n;
		n = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
		return n[CFG_W-1:0];
	endfunction

	// one generation of a row; left/right neighbors wrap at the last column in use
	function automatic row_t life_row(input row_t a, input row_t c, input row_t b,
			input logic [CW-1:0] wm);
		row_t al, ar, cl, cr, bl, br, res;
		logic [3:0] n;
		al = a << 1;
		cl = c << 1;
		bl = b << 1;
		ar = a >> 1;
		cr = c >> 1;
		br = b >> 1;
		al[0] = a[wm];
		cl[0] = c[wm];
		bl[0] = b[wm];
		ar[wm] = a[0];
		cr[wm] = c[0];
		br[wm] = b[0];
		for (int x = 0; x < MAX_WIDTH; x++) begin
			n = 4'(al[x]) + 4'(a[x]) + 4'(ar[x]) + 4'(cl[x]) + 4'(cr[x])
				+ 4'(bl[x]) + 4'(b[x]) + 4'(br[x]);
			if (x > int'(wm)) begin
				res[x] = c[x];
			end else if (c[x]) begin
				res[x] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
			end else begin
				res[x] = (n == BIRTH_COUNT);
			end
		end
		return res;
	endfunction

	state_t                state_q;
	logic [CFG_W-1:0]      bw_q, bh_q;
	logic [CFG_W-1:0]      w_eff, h_eff;
	logic [CW-1:0]         wm1;
	logic [RA-1:0]         hm1;
	logic                  accept;
	logic                  ax_out, ay_out;

	logic [1:0]            op_q;
	logic [COORD_W-1:0]    ax_q, ay_q, py_q;
	logic [CFG_W-1:0]      ph_q;
	logic [CW-1:0]         bx_q;
	logic [RA-1:0]         by_q;
	logic [RA-1:0]         y_q;
	row_t                  above_q, cur_q, row0_q;
	row_t                  below, new_row, row_shift;

	logic                  mod_y_q, mod_neg_q;
	logic [2:0]            mod_cnt_q;
	logic [CFG_W-1:0]      mod_mag_q, mod_rem_q;
	logic [CFG_W-1:0]      mod_d, step_rem, fin_res;
	logic [CFG_W:0]        trial;
	logic signed [POS_W-1:0] vx, vy;

	row_t                  mem [MAX_HEIGHT];
	logic [MAX_HEIGHT-1:0] vld_q;
	row_t                  rd_q, rd_eff;
	logic                  rd_vld_q;
	logic [RA-1:0]         rd_addr, wr_addr;
	logic                  wr_en;
	row_t                  wr_data;

	logic                  done_q, cell_alive_q, ignored_q;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign cell_alive = cell_alive_q;
	assign ignored    = ignored_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= BOARD_SIZE_RESET;
			bh_q <= BOARD_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOARD_WIDTH: begin
					bw_q <= cfg_data;
				end
				CFG_BOARD_HEIGHT: begin
					bh_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (bw_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (int'(bw_q) > MAX_WIDTH) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = bw_q;
		end
		if (bh_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (int'(bh_q) > MAX_HEIGHT) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = bh_q;
		end
	end

	assign wm1    = CW'(w_eff - CFG_W'(1));
	assign hm1    = RA'(h_eff - CFG_W'(1));
	assign ax_out = ({1'b0, anchor_x} >= w_eff);
	assign ay_out = ({1'b0, anchor_y} >= h_eff);

	// shared remainder unit: restoring steps, then a fixup for negative offsets
	assign vx       = stamp_pos(pattern_x, anchor_x, pattern_width);
	assign vy       = stamp_pos(py_q, ay_q, ph_q);
	assign mod_d    = mod_y_q ? h_eff : w_eff;
	assign trial    = {mod_rem_q, mod_mag_q[CFG_W-1]};
	assign step_rem = (trial >= {1'b0, mod_d}) ? CFG_W'(trial - {1'b0, mod_d})
		: trial[CFG_W-1:0];
	assign fin_res  = (mod_neg_q && (mod_rem_q != '0)) ? (mod_d - mod_rem_q) : mod_rem_q;

	// row memory; rows never written since the last clear read as dead
	assign rd_eff    = rd_vld_q ? rd_q : '0;
	assign below     = (y_q == hm1) ? row0_q : rd_eff;
	assign new_row   = life_row(above_q, cur_q, below, wm1);
	assign row_shift = rd_eff >> ax_q;

	always_comb begin
		case (state_q)
			S_ADV_A: begin
				rd_addr = hm1;
			end
			S_ADV_C: begin
				rd_addr = (hm1 == '0) ? '0 : RA'(1);
			end
			S_ADV_ROW: begin
				// the last row takes its lower neighbor from the saved copy of row 0
				rd_addr = (int'(y_q) + 1 >= int'(hm1)) ? '0 : (y_q + RA'(2));
			end
			S_FETCH: begin
				rd_addr = (op_q == OP_READ) ? RA'(ay_q) : by_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_comb begin
		wr_en   = (state_q == S_ADV_ROW) || ((state_q == S_UPDATE) && (op_q == OP_STAMP));
		wr_addr = (state_q == S_ADV_ROW) ? y_q : by_q;
		wr_data = (state_q == S_ADV_ROW) ? new_row
			: (rd_eff ^ ({{(MAX_WIDTH-1){1'b0}}, 1'b1} << bx_q));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vld_q        <= '0;
			rd_vld_q     <= 1'b0;
			y_q          <= '0;
			mod_cnt_q    <= '0;
			mod_y_q      <= 1'b0;
			done_q       <= 1'b0;
			cell_alive_q <= 1'b0;
			ignored_q    <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			cell_alive_q <= 1'b0;
			ignored_q    <= 1'b0;
			rd_vld_q     <= vld_q[rd_addr];
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_ADVANCE: begin
								state_q <= S_ADV_A;
							end
							OP_CLEAR: begin
								vld_q  <= '0;
								done_q <= 1'b1;
							end
							default: begin
								if (ax_out || ay_out) begin
									done_q    <= 1'b1;
									ignored_q <= 1'b1;
								end else if (opcode == OP_READ) begin
									state_q <= S_FETCH;
								end else if (pattern_bit) begin
									state_q   <= S_MOD;
									mod_cnt_q <= '0;
									mod_y_q   <= 1'b0;
								end else begin
									done_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_ADV_A: begin
					state_q <= S_ADV_B;
				end
				S_ADV_B: begin
					state_q <= S_ADV_C;
				end
				S_ADV_C: begin
					y_q     <= '0;
					state_q <= S_ADV_ROW;
				end
				S_ADV_ROW: begin
					if (y_q == hm1) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						y_q <= y_q + RA'(1);
					end
				end
				S_MOD: begin
					if (mod_cnt_q == MOD_LAST) begin
						mod_cnt_q <= '0;
						if (mod_y_q) begin
							state_q <= S_FETCH;
						end else begin
							mod_y_q <= 1'b1;
						end
					end else begin
						mod_cnt_q <= mod_cnt_q + 3'd1;
					end
				end
				S_FETCH: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					done_q       <= 1'b1;
					cell_alive_q <= (op_q == OP_READ) && row_shift[0];
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= opcode;
					ax_q      <= anchor_x;
					ay_q      <= anchor_y;
					py_q      <= pattern_y;
					ph_q      <= pattern_height;
					mod_neg_q <= vx[POS_W-1];
					mod_mag_q <= pos_mag(vx);
					mod_rem_q <= '0;
				end
			end
			S_ADV_B: begin
				above_q <= rd_eff;
			end
			S_ADV_C: begin
				cur_q  <= rd_eff;
				row0_q <= rd_eff;
			end
			S_ADV_ROW: begin
				above_q <= cur_q;
				cur_q   <= below;
			end
			S_MOD: begin
				if (mod_cnt_q == MOD_LAST) begin
					if (!mod_y_q) begin
						bx_q      <= CW'(fin_res);
						mod_neg_q <= vy[POS_W-1];
						mod_mag_q <= pos_mag(vy);
						mod_rem_q <= '0;
					end else begin
						by_q <= RA'(fin_res);
					end
				end else begin
					mod_rem_q <= step_rem;
					mod_mag_q <= mod_mag_q << 1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/tla_checker.sv
`timescale 1ns / 1ps

`include "toroidal_life_automaton_defines.svh"

module tla_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] opcode,
	input logic       done,
	input logic       cell_alive,
	input logic       ignored
);
	import tla_pkg::*;

	// a result always frees the command channel in the same cycle
	`TLA_ASSERT_HOLD(a_done_frees, done, !busy, "result strobe while still busy")

	// advance always walks rows, so it cannot finish without going busy
	`TLA_ASSERT_NEXT(a_adv_busy, start && !busy && (opcode == OP_ADVANCE), busy && !done,
		"advance transaction did not go busy")

	`TLA_ASSERT_NEXT(a_clear_done, start && !busy && (opcode == OP_CLEAR),
		done && !cell_alive && !ignored && !busy, "clear transaction result wrong")

	// a live cell only comes back from an in-board read
	`TLA_ASSERT_HOLD(a_alive_clean, cell_alive, done && !ignored,
		"cell_alive outside a clean read result")

endmodule

bind toroidal_life_automaton tla_checker u_tla_checker (.*);
